// ===== rtl/rlew_pkg.sv =====
`default_nettype none

package rlew_pkg;

    localparam int WordWidth  = 16;
    localparam int TotalWidth = 32;
    localparam int CfgIdxWidth = 2;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CFG_RLEW_TAG   = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_MAP_WIDTH  = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_MAP_HEIGHT = 2'd2;

    localparam logic [WordWidth-1:0] TagReset    = 16'd0;
    localparam logic [WordWidth-1:0] WidthReset  = 16'd64;
    localparam logic [WordWidth-1:0] HeightReset = 16'd64;

    typedef struct packed {
        logic                  is_status;
        logic [WordWidth-1:0]  run_value;
        logic [WordWidth-1:0]  run_length;
        logic [TotalWidth-1:0] start_index;
        logic                  size_ok;
        logic                  truncated;
        logic                  last;
    } rlew_result_t;

    // Up to two results come out of one word, written to the queue together.
    typedef struct packed {
        logic [1:0]   count;
        rlew_result_t first;
        rlew_result_t second;
    } rlew_push_t;

endpackage

`default_nettype wire

// ===== rtl/rlew_core.sv =====
`default_nettype none

module rlew_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            fire,
    input  wire logic [rlew_pkg::WordWidth-1:0]  word,
    input  wire logic                            end_of_data,
    input  wire logic [rlew_pkg::WordWidth-1:0]  rlew_tag,
    input  wire logic [rlew_pkg::WordWidth-1:0]  map_width,
    input  wire logic [rlew_pkg::WordWidth-1:0]  map_height,
    output rlew_pkg::rlew_push_t                 push
);
    import rlew_pkg::*;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_NORMAL,
        PH_COUNT,
        PH_VALUE
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [WordWidth-1:0]  held_count_reg, held_count_next;
    logic [TotalWidth-1:0] total_reg, total_next;
    logic                  overflow_reg, overflow_next;

    logic                  emit_run;
    logic [WordWidth-1:0]  add_amt;
    logic [TotalWidth:0]   sum;
    logic [TotalWidth-1:0] total_sat;
    logic                  overflow_now;
    phase_t                phase_run;
    logic [WordWidth-1:0]  held_run;
    logic [TotalWidth-1:0] expect_size;
    rlew_result_t          run_res;
    rlew_result_t          stat_res;

    always_comb
    begin
        phase_run = phase_reg;
        held_run  = held_count_reg;
        emit_run  = 1'b0;
        add_amt   = '0;
        unique case (phase_reg)
            PH_LEAD:
            begin
                phase_run = PH_NORMAL;
            end
            PH_NORMAL:
            begin
                if (word == rlew_tag)
                begin
                    phase_run = PH_COUNT;
                end
                else
                begin
                    emit_run = 1'b1;
                    add_amt  = WordWidth'(1);
                end
            end
            PH_COUNT:
            begin
                held_run  = word;
                phase_run = PH_VALUE;
            end
            PH_VALUE:
            begin
                // A triple with a zero count produces nothing.
                if (held_count_reg != '0)
                begin
                    emit_run = 1'b1;
                    add_amt  = held_count_reg;
                end
                held_run  = '0;
                phase_run = PH_NORMAL;
            end
            default:
            begin
                phase_run = PH_LEAD;
            end
        endcase
    end

    assign sum          = {1'b0, total_reg} + {{(TotalWidth-WordWidth+1){1'b0}}, add_amt};
    assign total_sat    = sum[TotalWidth] ? '1 : sum[TotalWidth-1:0];
    assign overflow_now = overflow_reg | sum[TotalWidth];
    assign expect_size  = {{(TotalWidth-WordWidth){1'b0}}, map_width}
                        * {{(TotalWidth-WordWidth){1'b0}}, map_height};

    always_comb
    begin
        run_res.is_status   = 1'b0;
        run_res.run_value   = word;
        run_res.run_length  = add_amt;
        run_res.start_index = total_reg;
        run_res.size_ok     = 1'b0;
        run_res.truncated   = 1'b0;
        run_res.last        = ~end_of_data;

        stat_res.is_status   = 1'b1;
        stat_res.run_value   = '0;
        stat_res.run_length  = '0;
        stat_res.start_index = total_sat;
        stat_res.size_ok     = ~overflow_now && (total_sat == expect_size);
        stat_res.truncated   = (phase_run == PH_COUNT) || (phase_run == PH_VALUE);
        stat_res.last        = 1'b1;
    end

    always_comb
    begin
        push.count  = fire ? ({1'b0, emit_run} + {1'b0, end_of_data}) : 2'd0;
        push.first  = emit_run ? run_res : stat_res;
        push.second = stat_res;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        held_count_next = held_count_reg;
        total_next      = total_reg;
        overflow_next   = overflow_reg;
        if (fire)
        begin
            if (end_of_data)
            begin
                phase_next      = PH_LEAD;
                held_count_next = '0;
                total_next      = '0;
                overflow_next   = 1'b0;
            end
            else
            begin
                phase_next      = phase_run;
                held_count_next = held_run;
                total_next      = total_sat;
                overflow_next   = overflow_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEAD;
            held_count_reg <= '0;
            total_reg      <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_count_reg <= held_count_next;
            total_reg      <= total_next;
            overflow_reg   <= overflow_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rlew_out_fifo.sv =====
`default_nettype none

module rlew_out_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rlew_pkg::rlew_push_t push,
    output logic                      room,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output rlew_pkg::rlew_result_t    head
);
    import rlew_pkg::*;

    localparam int Depth    = 4;
    localparam int PtrWidth = $clog2(Depth);
    localparam int CntWidth = $clog2(Depth + 1);

    rlew_result_t          entry_reg [Depth];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0]   count_reg, count_next;
    logic [PtrWidth-1:0]   wr_ptr_plus1;
    logic                  pop;

    assign out_valid    = (count_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];
    assign pop          = out_valid & ~out_stall;
    // Room for the worst case of two results from one word.
    assign room         = (count_reg <= CntWidth'(Depth - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + PtrWidth'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PtrWidth'(push.count);
        rd_ptr_next = rd_ptr_reg + PtrWidth'(pop);
        count_next  = count_reg + CntWidth'(push.count) - CntWidth'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rlew_run_decoder.sv =====
// Channel   Signals                                              Direction
// ------    ---------------------------------------------------  ---------
// in        in_valid, in_stall, data_word, end_of_data           sink
// out       out_valid, out_stall, is_status, run_value,          source
//           run_length, start_index, size_ok, truncated, last
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data            sink
//
// One word is taken per cycle unless a held word waits for queue room; a
// taken word is held in a register and decoded when the output queue has
// room. A word that gives a run and ends the stream gives two results, which
// leave one at a time through a four-entry output queue.
// Reset loads tag 0 and a 64 by 64 plane and waits for a stream's leading word.
// out_stall never reaches in_stall in the same cycle; input stalls only when
// the output queue is near full.
`default_nettype none

module rlew_run_decoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [rlew_pkg::WordWidth-1:0]    data_word,
    input  wire logic                              end_of_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   is_status,
    output logic [rlew_pkg::WordWidth-1:0]         run_value,
    output logic [rlew_pkg::WordWidth-1:0]         run_length,
    output logic [rlew_pkg::TotalWidth-1:0]        start_index,
    output logic                                   size_ok,
    output logic                                   truncated,
    output logic                                   last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rlew_pkg::CfgIdxWidth-1:0]  cfg_index,
    input  wire logic [rlew_pkg::WordWidth-1:0]    cfg_data
);
    import rlew_pkg::*;

    logic [WordWidth-1:0] tag_reg;
    logic [WordWidth-1:0] width_reg;
    logic [WordWidth-1:0] height_reg;

    logic                 hold_valid_reg;
    logic [WordWidth-1:0] hold_word_reg;
    logic                 hold_end_reg;

    logic                 room;
    logic                 fire;
    logic                 take;
    rlew_push_t           push;
    rlew_result_t         head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg    <= TagReset;
            width_reg  <= WidthReset;
            height_reg <= HeightReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RLEW_TAG:   tag_reg    <= cfg_data;
                CFG_MAP_WIDTH:  width_reg  <= cfg_data;
                CFG_MAP_HEIGHT: height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign fire     = hold_valid_reg & room;
    assign in_stall = hold_valid_reg & ~room;
    assign take     = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (take || fire)
        begin
            hold_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_word_reg <= data_word;
            hold_end_reg  <= end_of_data;
        end
    end

    rlew_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .word        (hold_word_reg),
        .end_of_data (hold_end_reg),
        .rlew_tag    (tag_reg),
        .map_width   (width_reg),
        .map_height  (height_reg),
        .push        (push)
    );

    rlew_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign is_status   = head.is_status;
    assign run_value   = head.run_value;
    assign run_length  = head.run_length;
    assign start_index = head.start_index;
    assign size_ok     = head.size_ok;
    assign truncated   = head.truncated;
    assign last        = head.last;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rlew_pkg::*;

    localparam int SettleCycles = 8;
    localparam int LongHold = 300;
    localparam int IdleLimit = 2000;

    // Index 3 names no register; writes to it must be ignored.
    localparam logic [CfgIdxWidth-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        DEC_LEAD,
        DEC_NORMAL,
        DEC_COUNT,
        DEC_VALUE
    } dec_phase_e;

    typedef struct {
        logic [WordWidth-1:0] word;
        logic                 eod;
        int                   gap;
        bit                   drain;
    } pending_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [WordWidth-1:0]   data_word = '0;
    logic                   end_of_data = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   is_status;
    logic [WordWidth-1:0]   run_value;
    logic [WordWidth-1:0]   run_length;
    logic [TotalWidth-1:0]  start_index;
    logic                   size_ok;
    logic                   truncated;
    logic                   last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    logic [WordWidth-1:0]   cfg_data = '0;

    // Decoder state as the bench sees it.
    logic [WordWidth-1:0]  model_tag = TagReset;
    logic [WordWidth-1:0]  model_width = WidthReset;
    logic [WordWidth-1:0]  model_height = HeightReset;
    dec_phase_e            stream_phase = DEC_LEAD;
    logic [WordWidth-1:0]  held_count = '0;
    logic [TotalWidth-1:0] run_total = '0;
    logic                  run_overflow = 1'b0;

    pending_word_t pending_words[$];
    rlew_result_t  expected_runs[$];
    rlew_result_t  want;

    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    int   tx_waited = 0;
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b0;
    int   rx_wait = 0;
    int   rx_hold_left = 0;
    int   hold_requests = 0;
    int   holds_served = 0;
    int   idle_cycles = 0;
    int   mismatch_count = 0;

    rlew_run_decoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_word(data_word),
        .end_of_data(end_of_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .is_status(is_status),
        .run_value(run_value),
        .run_length(run_length),
        .start_index(start_index),
        .size_ok(size_ok),
        .truncated(truncated),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void add_to_total(input logic [WordWidth-1:0] n);
        logic [TotalWidth:0] sum;
        sum = {1'b0, run_total} + {{(TotalWidth - WordWidth + 1){1'b0}}, n};
        if (sum[TotalWidth])
        begin
            run_total = '1;
            run_overflow = 1'b1;
        end
        else
        begin
            run_total = sum[TotalWidth-1:0];
        end
    endfunction

    function automatic rlew_result_t run_word(input logic [WordWidth-1:0] v,
                                              input logic [WordWidth-1:0] len);
        rlew_result_t r;
        r = '0;
        r.run_value = v;
        r.run_length = len;
        r.start_index = run_total;
        return r;
    endfunction

    task automatic predict_word(input logic [WordWidth-1:0] w, input logic eod);
        rlew_result_t made[$];
        rlew_result_t r;
        logic [TotalWidth-1:0] plane_words;
        case (stream_phase)
            DEC_LEAD:
                stream_phase = DEC_NORMAL;
            DEC_NORMAL:
                if (w == model_tag)
                begin
                    stream_phase = DEC_COUNT;
                end
                else
                begin
                    made = {made, run_word(w, 16'd1)};
                    add_to_total(16'd1);
                end
            DEC_COUNT:
            begin
                held_count = w;
                stream_phase = DEC_VALUE;
            end
            default:
            begin
                if (held_count != 0)
                begin
                    made = {made, run_word(w, held_count)};
                    add_to_total(held_count);
                end
                held_count = '0;
                stream_phase = DEC_NORMAL;
            end
        endcase
        if (eod)
        begin
            plane_words = 32'(model_width) * 32'(model_height);
            r = '0;
            r.is_status = 1'b1;
            r.start_index = run_total;
            r.size_ok = !run_overflow && run_total == plane_words;
            r.truncated = stream_phase == DEC_COUNT || stream_phase == DEC_VALUE;
            made = {made, r};
            stream_phase = DEC_LEAD;
            held_count = '0;
            run_total = '0;
            run_overflow = 1'b0;
        end
        foreach (made[i])
        begin
            r = made[i];
            r.last = i == made.size() - 1;
            expected_runs = {expected_runs, r};
        end
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want_v,
                                          input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // Monitor: checks results, predicts accepted words, tracks register writes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_runs.size() == 0)
                begin
                    $error("result with nothing expected: value 0x%0h length %0d",
                           run_value, run_length);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_runs.pop_front();
                    compare_field("is_status", 32'(want.is_status), 32'(is_status));
                    compare_field("run_value", 32'(want.run_value), 32'(run_value));
                    compare_field("run_length", 32'(want.run_length), 32'(run_length));
                    compare_field("start_index", want.start_index, start_index);
                    compare_field("size_ok", 32'(want.size_ok), 32'(size_ok));
                    compare_field("truncated", 32'(want.truncated), 32'(truncated));
                    compare_field("last", 32'(want.last), 32'(last));
                end
            end
            if (in_valid && !in_stall)
                predict_word(data_word, end_of_data);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RLEW_TAG:   model_tag = cfg_data;
                    CFG_MAP_WIDTH:  model_width = cfg_data;
                    CFG_MAP_HEIGHT: model_height = cfg_data;
                    default: ;
                endcase
            end
        end
        in_fire <= rst_n && in_valid && !in_stall;
        out_fire <= rst_n && out_valid && !out_stall;
    end

    // Word driver. A word flagged drain waits until every expected result has arrived.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_fire))
        begin
            if (pending_words.size() == 0
                    || (pending_words[0].drain && expected_runs.size() != 0))
            begin
                in_valid <= 1'b0;
            end
            else if (tx_waited < pending_words[0].gap)
            begin
                tx_waited = tx_waited + 1;
                in_valid <= 1'b0;
            end
            else
            begin
                tx_waited = 0;
                in_valid <= 1'b1;
                data_word <= pending_words[0].word;
                end_of_data <= pending_words[0].eod;
                void'(pending_words.pop_front());
            end
        end
    end

    // Result receiver: a random pause after each result unless rx_calm, plus requested long holds.
    always @(negedge clk)
    begin
        if (holds_served < hold_requests)
        begin
            holds_served = holds_served + 1;
            rx_hold_left = LongHold;
        end
        if (out_fire)
            rx_wait = rx_calm ? 0 : $urandom_range(0, 3);
        if (rx_hold_left > 0)
        begin
            rx_hold_left = rx_hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (rx_wait > 0)
        begin
            rx_wait = rx_wait - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == IdleLimit)
        begin
            $display("watchdog: no transfer for %0d cycles", IdleLimit);
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_word(input logic [WordWidth-1:0] w, input logic eod,
                             input bit drain = 1'b0);
        pending_word_t p;
        p.word = w;
        p.eod = eod;
        p.drain = drain;
        p.gap = tx_calm ? 0 : $urandom_range(0, 3);
        pending_words = {pending_words, p};
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                             input logic [WordWidth-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_runs.size() != 0)
            @(negedge clk);
        // Words that end with no result may still be in the pipeline.
        repeat (SettleCycles) @(posedge clk);
    endtask

    // A well-formed stream of literals and triples aiming at budget decoded words,
    // sometimes cut off inside a triple.
    task automatic queue_stream(input logic [WordWidth-1:0] tag, input int unsigned budget,
                                input int max_runs, input int unsigned max_count,
                                input bit drain);
        logic [WordWidth-1:0] ws[$];
        logic [WordWidth-1:0] w;
        int unsigned total;
        int unsigned room;
        int unsigned cnt;
        int runs;
        total = 0;
        runs = 0;
        ws = {ws, 16'($urandom)};
        while (total < budget && runs < max_runs)
        begin
            room = budget - total;
            if (room > max_count)
                room = max_count;
            if ($urandom_range(0, 2) == 0)
            begin
                w = 16'($urandom);
                if (w == tag)
                    w = ~tag;
                ws = {ws, w};
                total += 1;
            end
            else
            begin
                cnt = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, room);
                ws = {ws, tag};
                ws = {ws, 16'(cnt)};
                ws = {ws, 16'($urandom)};
                total += cnt;
            end
            runs++;
        end
        case ($urandom_range(0, 7))
            0: ws = {ws, tag};
            1:
            begin
                ws = {ws, tag};
                ws = {ws, 16'($urandom)};
            end
            default: ;
        endcase
        foreach (ws[i])
            push_word(ws[i], i == ws.size() - 1, drain && i == 0);
    endtask

    task automatic queue_noise(input logic [WordWidth-1:0] tag);
        int len;
        int pick;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 3);
            push_word(pick == 0 ? tag : pick == 1 ? 16'($urandom_range(0, 3)) : 16'($urandom),
                      i == len - 1);
        end
    endtask

    initial
    begin
        logic [WordWidth-1:0] tag;
        logic [WordWidth-1:0] wid;
        logic [WordWidth-1:0] hgt;
        int unsigned plane;
        int unsigned budget;
        int unsigned max_count;
        int streams;

        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, tag 0: literal, triple, zero-count triple, a run and the
        // status from one word, then a stream of a single word.
        push_word(16'h1111, 1'b0);
        push_word(16'h0005, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'h0003, 1'b0);
        push_word(16'h0007, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'h0009, 1'b0);
        push_word(16'hFFFF, 1'b1);
        push_word(16'hFFFF, 1'b1);
        wait_idle();

        write_reg(CFG_RLEW_TAG, 16'hFFFF);
        write_reg(CFG_MAP_WIDTH, 16'd3);
        write_reg(CFG_MAP_HEIGHT, 16'd2);
        write_reg(CFG_SPARE, 16'hBEEF);
        @(posedge clk);
        // Exactly 3 x 2 words decoded; the run value equals the tag.
        push_word(16'hFFFF, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0002, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0001, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'h1234, 1'b0);
        push_word(16'h8000, 1'b1);
        // Streams that end waiting for a count, then waiting for a value.
        push_word(16'h0000, 1'b0);
        push_word(16'hFFFF, 1'b1);
        push_word(16'h7777, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h0003, 1'b1);
        wait_idle();

        write_reg(CFG_MAP_WIDTH, 16'd0);
        write_reg(CFG_MAP_HEIGHT, 16'd0);
        @(posedge clk);
        push_word(16'h5A5A, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    tag = 16'h0000;
                    wid = 16'($urandom_range(1, 8));
                    hgt = 16'($urandom_range(1, 8));
                end
                1:
                begin
                    tag = 16'hFFFF;
                    wid = 16'($urandom_range(1, 8));
                    hgt = 16'($urandom_range(1, 8));
                end
                2:
                begin
                    tag = 16'($urandom);
                    wid = 16'hFFFF;
                    hgt = 16'hFFFF;
                end
                3:
                begin
                    tag = 16'($urandom_range(0, 3));
                    wid = 16'h0000;
                    hgt = 16'($urandom);
                end
                default:
                begin
                    tag = 16'($urandom);
                    wid = 16'($urandom_range(1, 16));
                    hgt = 16'($urandom_range(1, 4));
                end
            endcase
            write_reg(CFG_RLEW_TAG, tag);
            write_reg(CFG_MAP_WIDTH, wid);
            write_reg(CFG_MAP_HEIGHT, hgt);
            @(posedge clk);
            plane = 32'(wid) * 32'(hgt);
            max_count = (ph == 2) ? 65535 : 16;
            tx_calm = ph == 5 || ph == 6;
            rx_calm = ph == 1 || ph == 6;
            // The receiver holds off while words keep coming, so the input backs up.
            if (ph == 4)
                hold_requests++;
            streams = 0;
            while (pending_words.size() < 200)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    queue_noise(tag);
                end
                else
                begin
                    budget = ($urandom_range(0, 3) == 0) ? $urandom_range(0, plane + 2)
                                                         : plane;
                    queue_stream(tag, budget, (ph == 2) ? 6 : 40, max_count,
                                 streams % 6 == 0);
                end
                streams++;
            end
            wait_idle();
        end

        repeat (16) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
